/* rtl/bft_pkg.sv */
// Shared types and constants for the bidirectional flow byte table.
// Used by the front end, queue, table engine and top; depends on nothing else.
`timescale 1ns / 1ps

package bft_pkg;

  // Default number of table slots.
  localparam int unsigned FlowEntries = 64;

  localparam logic [7:0]  ProtoTcp    = 8'd6;
  localparam logic [6:0]  MinIpBytes  = 7'd20;
  localparam logic [15:0] PortMixA    = 16'hC0ED;
  localparam logic [15:0] PortMixB    = 16'hBABE;
  localparam logic [31:0] CounterMax  = 32'hFFFF_FFFF;
  localparam int unsigned SlotOutBits = 6;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_UPDATED  = 2'd1,
    ST_NOT_TCP  = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  // A classified request as it travels from the front to the back.
  typedef struct packed {
    logic        is_tcp;
    logic        short_hdr;
    logic        bad_len;
    logic [15:0] payload;
    logic [47:0] key;
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] now;
  } item_t;

  // One table entry as held in the slot memory.
  typedef struct packed {
    logic [47:0] key;
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] src_bytes;
    logic [31:0] dst_bytes;
    logic [31:0] first_time;
  } entry_t;

  localparam int unsigned EntryBits = $bits(entry_t);

endpackage

/* rtl/bidirectional_flow_byte_table.sv */
// Bidirectional TCP flow byte table: one header in, one status result out.
// Steps: pop the request from the queue, read and then compare each occupied slot in turn
// (at most FlowEntries slots) until the key matches, then decide and register the result.
// A new request is popped only once the result of the last one has been registered.
// Reset clears the slot fill count, the queue and the output; no memory clearing pass.
`timescale 1ns / 1ps

module bidirectional_flow_byte_table #(
  parameter int unsigned FlowEntries = bft_pkg::FlowEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dst_addr_i,
  input  logic [15:0] src_port_i,
  input  logic [15:0] dst_port_i,
  input  logic [7:0]  ip_protocol_i,
  input  logic [15:0] ip_total_length_i,
  input  logic [3:0]  ip_header_words_i,
  input  logic [3:0]  tcp_header_words_i,
  input  logic [31:0] now_seconds_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [5:0]  flow_slot_o,
  output logic        from_first_source_o,
  output logic        address_collision_o,
  output logic        short_ip_header_o,
  output logic        bad_payload_length_o,
  output logic [31:0] source_bytes_o,
  output logic [31:0] dest_bytes_o,
  output logic [31:0] first_seen_o
);

  bft_pkg::item_t front_item;
  bft_pkg::item_t q_item;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;

  // Classification of the incoming request.
  bft_front u_front (
    .src_addr_i         (src_addr_i),
    .dst_addr_i         (dst_addr_i),
    .src_port_i         (src_port_i),
    .dst_port_i         (dst_port_i),
    .ip_protocol_i      (ip_protocol_i),
    .ip_total_length_i  (ip_total_length_i),
    .ip_header_words_i  (ip_header_words_i),
    .tcp_header_words_i (tcp_header_words_i),
    .now_seconds_i      (now_seconds_i),
    .item_o             (front_item)
  );

  assign in_stall_o = q_full;

  // Decoupling queue.
  bft_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i && !q_full),
    .push_data_i (front_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .not_empty_o (q_valid),
    .pop_data_o  (q_item)
  );

  // Table engine and result register.
  bft_back #(
    .FlowEntries (FlowEntries)
  ) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .q_valid_i            (q_valid),
    .q_data_i             (q_item),
    .q_pop_o              (q_pop),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .status_o             (status_o),
    .flow_slot_o          (flow_slot_o),
    .from_first_source_o  (from_first_source_o),
    .address_collision_o  (address_collision_o),
    .short_ip_header_o    (short_ip_header_o),
    .bad_payload_length_o (bad_payload_length_o),
    .source_bytes_o       (source_bytes_o),
    .dest_bytes_o         (dest_bytes_o),
    .first_seen_o         (first_seen_o)
  );

endmodule

/* rtl/bft_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

module bft_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/bft_front.sv */
// Front end: classifies each header and works out payload, flags and flow key.
// Depends on bft_pkg.
`timescale 1ns / 1ps

module bft_front (
  input  logic [31:0]   src_addr_i,
  input  logic [31:0]   dst_addr_i,
  input  logic [15:0]   src_port_i,
  input  logic [15:0]   dst_port_i,
  input  logic [7:0]    ip_protocol_i,
  input  logic [15:0]   ip_total_length_i,
  input  logic [3:0]    ip_header_words_i,
  input  logic [3:0]    tcp_header_words_i,
  input  logic [31:0]   now_seconds_i,
  output bft_pkg::item_t item_o
);

  logic [6:0]  ip_bytes;
  logic [6:0]  hdr_bytes;
  logic [16:0] diff;

  // Header lengths in bytes and the signed payload length.
  assign ip_bytes  = {1'b0, ip_header_words_i, 2'b00};
  assign hdr_bytes = ip_bytes + {1'b0, tcp_header_words_i, 2'b00};
  assign diff      = {1'b0, ip_total_length_i} - {10'd0, hdr_bytes};

  // Classification and key that both directions share.
  always_comb begin
    item_o.is_tcp    = (ip_protocol_i == bft_pkg::ProtoTcp);
    item_o.short_hdr = (ip_bytes < bft_pkg::MinIpBytes);
    item_o.bad_len   = diff[16];
    item_o.payload   = diff[16] ? 16'd0 : diff[15:0];
    item_o.key       = {src_addr_i ^ dst_addr_i,
                        (dst_port_i ^ bft_pkg::PortMixA) ^ (src_port_i ^ bft_pkg::PortMixB)};
    item_o.src       = src_addr_i;
    item_o.dst       = dst_addr_i;
    item_o.now       = now_seconds_i;
  end

endmodule

/* rtl/bft_queue.sv */
// Two-entry queue that decouples the front end from the table engine.
// Depends on bft_pkg.
`timescale 1ns / 1ps

module bft_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bft_pkg::item_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           not_empty_o,
  output bft_pkg::item_t pop_data_o
);

  bft_pkg::item_t slot_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage for queued requests.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign full_o      = (cnt_q == 2'd2);
  assign not_empty_o = (cnt_q != 2'd0);
  assign pop_data_o  = slot_q[rd_ptr_q];

endmodule

/* rtl/bft_back.sv */
// Table engine: scans the occupied slots for a TCP key, then updates, inserts or reports a full table.
// Depends on bft_pkg and bft_ram.
`timescale 1ns / 1ps

module bft_back #(
  parameter int unsigned FlowEntries = bft_pkg::FlowEntries
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  bft_pkg::item_t q_data_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [1:0]     status_o,
  output logic [5:0]     flow_slot_o,
  output logic           from_first_source_o,
  output logic           address_collision_o,
  output logic           short_ip_header_o,
  output logic           bad_payload_length_o,
  output logic [31:0]    source_bytes_o,
  output logic [31:0]    dest_bytes_o,
  output logic [31:0]    first_seen_o
);

  localparam int unsigned AW = $clog2(FlowEntries);
  localparam int unsigned CW = $clog2(FlowEntries + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CMP  = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  bft_pkg::item_t  item_q, item_d;
  logic [AW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   fill_q, fill_d;
  logic            hit_q, hit_d;

  logic            out_valid_q;
  logic [1:0]      status_q, status_d;
  logic [5:0]      slot_q, slot_d;
  logic            fwd_q, fwd_d;
  logic            coll_q, coll_d;
  logic            short_q, short_d;
  logic            bad_q, bad_d;
  logic [31:0]     sbytes_q, sbytes_d;
  logic [31:0]     dbytes_q, dbytes_d;
  logic [31:0]     first_q, first_d;

  logic                 rd_en;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  bft_pkg::entry_t      wr_entry;
  bft_pkg::entry_t      rd_entry;
  logic [bft_pkg::EntryBits-1:0] rd_raw;

  logic            out_free;
  logic            fwd;
  logic            coll;
  logic [32:0]     sum;
  logic [31:0]     sat_sum;
  logic [AW+5:0]   slot_ext;
  logic [CW-1:0]   idx_next;
  logic            table_full;

  bft_ram #(
    .Width (bft_pkg::EntryBits),
    .Depth (FlowEntries)
  ) u_slots (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_entry),
    .rd_en_i   (rd_en),
    .rd_addr_i (idx_q),
    .rd_data_o (rd_raw)
  );

  assign rd_entry = bft_pkg::entry_t'(rd_raw);

  // Match details and saturating update of the selected counter.
  assign fwd     = (item_q.src == rd_entry.src);
  assign coll    = ((item_q.src != rd_entry.src) && (item_q.src != rd_entry.dst)) ||
                   ((item_q.dst != rd_entry.src) && (item_q.dst != rd_entry.dst));
  assign sum     = {1'b0, fwd ? rd_entry.src_bytes : rd_entry.dst_bytes} +
                   {17'd0, item_q.payload};
  assign sat_sum = sum[32] ? bft_pkg::CounterMax : sum[31:0];

  assign out_free   = !out_valid_q || !out_stall_i;
  assign idx_next   = CW'(idx_q) + CW'(1);
  assign table_full = (fill_q == CW'(FlowEntries));

  // Sequencer for scan, decision and write-back.
  always_comb begin
    state_d  = state_q;
    item_d   = item_q;
    idx_d    = idx_q;
    fill_d   = fill_q;
    hit_d    = hit_q;
    q_pop_o  = 1'b0;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = idx_q;
    wr_entry = rd_entry;
    slot_ext = {6'd0, idx_q};

    status_d = status_q;
    slot_d   = slot_q;
    fwd_d    = fwd_q;
    coll_d   = coll_q;
    short_d  = short_q;
    bad_d    = bad_q;
    sbytes_d = sbytes_q;
    dbytes_d = dbytes_q;
    first_d  = first_q;

    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          item_d  = q_data_i;
          idx_d   = '0;
          hit_d   = 1'b0;
          if (!q_data_i.is_tcp || fill_q == '0) begin
            state_d = S_EMIT;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        rd_en   = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (rd_entry.key == item_q.key) begin
          hit_d   = 1'b1;
          state_d = S_EMIT;
        end else if (idx_next == fill_q) begin
          state_d = S_EMIT;
        end else begin
          idx_d   = idx_next[AW-1:0];
          state_d = S_READ;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_d  = S_IDLE;
          status_d = bft_pkg::ST_NOT_TCP;
          slot_d   = '0;
          fwd_d    = 1'b0;
          coll_d   = 1'b0;
          short_d  = 1'b0;
          bad_d    = 1'b0;
          sbytes_d = '0;
          dbytes_d = '0;
          first_d  = '0;
          if (item_q.is_tcp) begin
            short_d = item_q.short_hdr;
            bad_d   = item_q.bad_len;
            if (hit_q) begin
              // Existing flow: bump one direction's counter.
              wr_en    = 1'b1;
              wr_addr  = idx_q;
              wr_entry = rd_entry;
              if (fwd) begin
                wr_entry.src_bytes = sat_sum;
              end else begin
                wr_entry.dst_bytes = sat_sum;
              end
              status_d = bft_pkg::ST_UPDATED;
              slot_ext = {6'd0, idx_q};
              slot_d   = slot_ext[5:0];
              fwd_d    = fwd;
              coll_d   = coll;
              sbytes_d = fwd ? sat_sum : rd_entry.src_bytes;
              dbytes_d = fwd ? rd_entry.dst_bytes : sat_sum;
              first_d  = rd_entry.first_time;
            end else if (table_full) begin
              status_d = bft_pkg::ST_FULL;
            end else begin
              // New flow in the lowest free slot.
              wr_en               = 1'b1;
              wr_addr             = fill_q[AW-1:0];
              wr_entry.key        = item_q.key;
              wr_entry.src        = item_q.src;
              wr_entry.dst        = item_q.dst;
              wr_entry.src_bytes  = {16'd0, item_q.payload};
              wr_entry.dst_bytes  = '0;
              wr_entry.first_time = item_q.now;
              fill_d              = fill_q + {{(CW-1){1'b0}}, 1'b1};
              status_d            = bft_pkg::ST_INSERTED;
              slot_ext            = {6'd0, fill_q[AW-1:0]};
              slot_d              = slot_ext[5:0];
              fwd_d               = 1'b1;
              sbytes_d            = {16'd0, item_q.payload};
              first_d             = item_q.now;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      if (state_q == S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    idx_q    <= idx_d;
    hit_q    <= hit_d;
    status_q <= status_d;
    slot_q   <= slot_d;
    fwd_q    <= fwd_d;
    coll_q   <= coll_d;
    short_q  <= short_d;
    bad_q    <= bad_d;
    sbytes_q <= sbytes_d;
    dbytes_q <= dbytes_d;
    first_q  <= first_d;
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = status_q;
  assign flow_slot_o          = slot_q;
  assign from_first_source_o  = fwd_q;
  assign address_collision_o  = coll_q;
  assign short_ip_header_o    = short_q;
  assign bad_payload_length_o = bad_q;
  assign source_bytes_o       = sbytes_q;
  assign dest_bytes_o         = dbytes_q;
  assign first_seen_o         = first_q;

endmodule

/* bench/bidirectional_flow_byte_table_checker.sv */
// Checker for the bidirectional flow byte table: watches both channels,
// predicts each result from its own copy of the flow table and compares.
// Depends on bft_pkg for the status codes and the port mixing constants.
`timescale 1ns / 1ps

module bidirectional_flow_byte_table_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dst_addr_i,
  input  logic [15:0] src_port_i,
  input  logic [15:0] dst_port_i,
  input  logic [7:0]  ip_protocol_i,
  input  logic [15:0] ip_total_length_i,
  input  logic [3:0]  ip_header_words_i,
  input  logic [3:0]  tcp_header_words_i,
  input  logic [31:0] now_seconds_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  status_i,
  input  logic [5:0]  flow_slot_i,
  input  logic        from_first_source_i,
  input  logic        address_collision_i,
  input  logic        short_ip_header_i,
  input  logic        bad_payload_length_i,
  input  logic [31:0] source_bytes_i,
  input  logic [31:0] dest_bytes_i,
  input  logic [31:0] first_seen_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int Slots = 64;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic        fwd;
    logic        collision;
    logic        short_hdr;
    logic        bad_len;
    logic [31:0] src_bytes;
    logic [31:0] dst_bytes;
    logic [31:0] first_seen;
  } flow_result_t;

  // Shadow copy of the flow table.
  logic        shadow_valid [Slots];
  logic [47:0] shadow_key [Slots];
  logic [31:0] shadow_src [Slots];
  logic [31:0] shadow_dst [Slots];
  logic [31:0] shadow_src_bytes [Slots];
  logic [31:0] shadow_dst_bytes [Slots];
  logic [31:0] shadow_first [Slots];

  flow_result_t expected_flows[$];

  function automatic logic [31:0] add_saturating(logic [31:0] a, logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32] ? bft_pkg::CounterMax : sum[31:0];
  endfunction

  // Works out the result of one request and updates the shadow table.
  function automatic flow_result_t classify_header(
      logic [31:0] src, logic [31:0] dst, logic [15:0] sport, logic [15:0] dport,
      logic [7:0] proto, logic [15:0] total, logic [3:0] ihw, logic [3:0] thw,
      logic [31:0] now);
    flow_result_t r;
    int diff;
    logic [31:0] payload;
    logic [47:0] key;
    int hit;
    int vacant;
    logic [31:0] s;
    logic [31:0] d;
    r = '0;
    hit = -1;
    vacant = -1;
    if (proto != bft_pkg::ProtoTcp) begin
      r.status = bft_pkg::ST_NOT_TCP;
      return r;
    end
    r.short_hdr = (int'(ihw) * 4) < 20;
    diff = int'(total) - int'(ihw) * 4 - int'(thw) * 4;
    r.bad_len = diff < 0;
    payload = r.bad_len ? 32'd0 : 32'(diff);
    key = {src ^ dst, (dport ^ bft_pkg::PortMixA) ^ (sport ^ bft_pkg::PortMixB)};
    for (int i = 0; i < Slots; i++) begin
      if (shadow_valid[i]) begin
        if (hit < 0 && shadow_key[i] == key) hit = i;
      end else if (vacant < 0) begin
        vacant = i;
      end
    end
    if (hit >= 0) begin
      s = shadow_src[hit];
      d = shadow_dst[hit];
      r.fwd = (src == s);
      r.collision = (src != s && src != d) || (dst != s && dst != d);
      if (r.fwd) shadow_src_bytes[hit] = add_saturating(shadow_src_bytes[hit], payload);
      else shadow_dst_bytes[hit] = add_saturating(shadow_dst_bytes[hit], payload);
      r.status = bft_pkg::ST_UPDATED;
      r.slot = 6'(hit);
      r.src_bytes = shadow_src_bytes[hit];
      r.dst_bytes = shadow_dst_bytes[hit];
      r.first_seen = shadow_first[hit];
    end else if (vacant < 0) begin
      r.status = bft_pkg::ST_FULL;
    end else begin
      shadow_valid[vacant] = 1'b1;
      shadow_key[vacant] = key;
      shadow_src[vacant] = src;
      shadow_dst[vacant] = dst;
      shadow_src_bytes[vacant] = payload;
      shadow_dst_bytes[vacant] = '0;
      shadow_first[vacant] = now;
      r.status = bft_pkg::ST_INSERTED;
      r.slot = 6'(vacant);
      r.fwd = 1'b1;
      r.src_bytes = payload;
      r.first_seen = now;
    end
    return r;
  endfunction

  // Predict on each accepted request and compare each accepted result.
  always @(posedge clk_i or negedge rst_ni) begin
    flow_result_t seen;
    flow_result_t want;
    int pushed;
    int popped;
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) shadow_valid[i] = 1'b0;
      expected_flows.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      pushed = 0;
      popped = 0;
      if (in_valid_i && !in_stall_i) begin
        expected_flows.insert(expected_flows.size(), classify_header(src_addr_i,
            dst_addr_i, src_port_i, dst_port_i, ip_protocol_i, ip_total_length_i,
            ip_header_words_i, tcp_header_words_i, now_seconds_i));
        pushed = 1;
      end
      if (out_valid_i && !out_stall_i) begin
        seen = {status_i, flow_slot_i, from_first_source_i, address_collision_i,
                short_ip_header_i, bad_payload_length_i, source_bytes_i, dest_bytes_i,
                first_seen_i};
        if (expected_flows.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $time, seen);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_flows.pop_front();
          popped = 1;
          if (seen != want) begin
            $display("%0t: result differs, expected %p, actual %p", $time, want, seen);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= pending_o + pushed - popped;
    end
  end

endmodule

/* bench/bidirectional_flow_byte_table_test.sv */
// Top of the flow table testbench: clock, reset, request stimulus and verdict.
// Depends on bidirectional_flow_byte_table and its checker module.
`timescale 1ns / 1ps

module bidirectional_flow_byte_table_test;

  localparam int PoolSize = 96;
  localparam int IdleLimit = 3000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] src_addr = '0;
  logic [31:0] dst_addr = '0;
  logic [15:0] src_port = '0;
  logic [15:0] dst_port = '0;
  logic [7:0]  ip_protocol = '0;
  logic [15:0] ip_total_length = '0;
  logic [3:0]  ip_header_words = '0;
  logic [3:0]  tcp_header_words = '0;
  logic [31:0] now_seconds = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [5:0]  flow_slot;
  logic        from_first_source;
  logic        address_collision;
  logic        short_ip_header;
  logic        bad_payload_length;
  logic [31:0] source_bytes;
  logic [31:0] dest_bytes;
  logic [31:0] first_seen;
  int          fail_count;
  int          pending;
  logic        quiet = 1'b0;
  logic        idling = 1'b0;
  int          idle_cycles = 0;

  // Flow pool for the random part.
  logic [31:0] pool_src [PoolSize];
  logic [31:0] pool_dst [PoolSize];
  logic [15:0] pool_sport [PoolSize];
  logic [15:0] pool_dport [PoolSize];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bidirectional_flow_byte_table u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .src_addr_i(src_addr), .dst_addr_i(dst_addr),
    .src_port_i(src_port), .dst_port_i(dst_port),
    .ip_protocol_i(ip_protocol), .ip_total_length_i(ip_total_length),
    .ip_header_words_i(ip_header_words), .tcp_header_words_i(tcp_header_words),
    .now_seconds_i(now_seconds),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .flow_slot_o(flow_slot),
    .from_first_source_o(from_first_source), .address_collision_o(address_collision),
    .short_ip_header_o(short_ip_header), .bad_payload_length_o(bad_payload_length),
    .source_bytes_o(source_bytes), .dest_bytes_o(dest_bytes), .first_seen_o(first_seen)
  );

  bidirectional_flow_byte_table_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .src_addr_i(src_addr), .dst_addr_i(dst_addr),
    .src_port_i(src_port), .dst_port_i(dst_port),
    .ip_protocol_i(ip_protocol), .ip_total_length_i(ip_total_length),
    .ip_header_words_i(ip_header_words), .tcp_header_words_i(tcp_header_words),
    .now_seconds_i(now_seconds),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .status_i(status), .flow_slot_i(flow_slot),
    .from_first_source_i(from_first_source), .address_collision_i(address_collision),
    .short_ip_header_i(short_ip_header), .bad_payload_length_i(bad_payload_length),
    .source_bytes_i(source_bytes), .dest_bytes_i(dest_bytes), .first_seen_i(first_seen),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Result side stalls in random bursts, with calm stretches between them.
  always @(negedge clk) begin
    if (quiet || !rst_n) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 19) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      out_stall <= 1'b0;
      repeat ($urandom_range(0, 40)) @(negedge clk);
    end
  end

  // Watchdog: ends the run when nothing has been accepted for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("bidirectional_flow_byte_table: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Drives one request at the falling edge and holds it until accepted.
  task automatic send_header(logic [31:0] src, logic [31:0] dst, logic [15:0] sport,
      logic [15:0] dport, logic [7:0] proto, logic [15:0] total, logic [3:0] ihw,
      logic [3:0] thw);
    int gap;
    gap = 0;
    if (idling && !quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 12);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    src_addr = src;
    dst_addr = dst;
    src_port = sport;
    dst_port = dport;
    ip_protocol = proto;
    ip_total_length = total;
    ip_header_words = ihw;
    tcp_header_words = thw;
    now_seconds = $urandom();
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int idx;
    int tcp_sent;
    logic [31:0] mask;
    logic [31:0] s;
    logic [31:0] d;
    logic [15:0] sp;
    logic [15:0] dp;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: protocol extremes, header length extremes and negative payloads.
    send_header('0, '0, '0, '0, 8'd0, '0, '0, '0);
    send_header('1, '1, '1, '1, 8'd255, '1, '1, '1);
    send_header(32'h0A00_0001, 32'h0A00_0002, 16'd80, 16'd4000, bft_pkg::ProtoTcp,
        16'd100, 4'd5, 4'd5);
    send_header(32'h0A00_0002, 32'h0A00_0001, 16'd4000, 16'd80, bft_pkg::ProtoTcp,
        16'd60, 4'd5, 4'd5);
    send_header('0, '0, '0, '0, bft_pkg::ProtoTcp, '0, '0, '0);
    send_header('1, '1, '1, '1, bft_pkg::ProtoTcp, '1, '1, '1);
    send_header('1, '0, '0, '1, bft_pkg::ProtoTcp, 16'd10, 4'd4, 4'd0);
    send_header('1, '0, '0, '1, bft_pkg::ProtoTcp, 16'd200, 4'd15, 4'd15);
    // Same key with a different address pair: an address collision.
    send_header(32'h0A00_00F1, 32'h0A00_00F2, 16'd80, 16'd4000, bft_pkg::ProtoTcp,
        16'd40, 4'd5, 4'd5);
    send_header(32'h1234_5678, 32'h8765_4321, 16'd7, 16'd7, 8'd17, 16'd500, 4'd5, 4'd5);

    // Large payloads on one flow in both directions.
    for (int i = 0; i < 20; i++) begin
      send_header(32'h0A00_0001, 32'h0A00_0002, 16'd80, 16'd4000, bft_pkg::ProtoTcp,
          '1, 4'd5, 4'd5);
      send_header(32'h0A00_0002, 32'h0A00_0001, 16'd4000, 16'd80, bft_pkg::ProtoTcp,
          '1, 4'd5, 4'd5);
    end
    wait_for_results();

    // Random part: a flow pool larger than the table, so that it fills up.
    for (int i = 0; i < PoolSize; i++) begin
      pool_src[i] = $urandom();
      pool_dst[i] = $urandom();
      pool_sport[i] = 16'($urandom());
      pool_dport[i] = 16'($urandom());
    end
    idling = 1'b1;
    tcp_sent = 0;
    while (tcp_sent < 620) begin
      if (tcp_sent == 300) begin
        wait_for_results();
        tcp_sent++;
      end
      if (tcp_sent >= 540) quiet = 1'b1;
      idx = $urandom_range(0, PoolSize - 1);
      s = pool_src[idx];
      d = pool_dst[idx];
      sp = pool_sport[idx];
      dp = pool_dport[idx];
      if ($urandom_range(0, 9) == 0) begin
        // Same key with shifted addresses.
        mask = $urandom();
        s = s ^ mask;
        d = d ^ mask;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_header($urandom(), $urandom(), 16'($urandom()), 16'($urandom()),
            8'($urandom_range(0, 255)), 16'($urandom()), 4'($urandom()),
            4'($urandom()));
      end else if ($urandom_range(0, 1) == 0) begin
        send_header(s, d, sp, dp, bft_pkg::ProtoTcp, 16'($urandom()), 4'($urandom()),
            4'($urandom()));
        tcp_sent++;
      end else begin
        send_header(d, s, dp, sp, bft_pkg::ProtoTcp, 16'($urandom_range(0, 1500)),
            4'($urandom_range(5, 15)), 4'($urandom_range(5, 15)));
        tcp_sent++;
      end
    end
    wait_for_results();
    repeat (300) @(negedge clk);
    if (fail_count == 0) begin
      $display("bidirectional_flow_byte_table: match");
    end else begin
      $display("bidirectional_flow_byte_table: mismatch");
    end
    $finish;
  end

endmodule
